// ===== rtl/pmd_pkg.sv =====
// Shared types, register and format codes, and constants for the PCM downmix block.
package pmd_pkg;

    localparam int MAX_CHANNELS_DEF = 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    localparam int FMT_W      = 3;
    localparam int COUNT_W    = 4;
    localparam int MONO_W     = 25;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FORMAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 2'd1;

    // sample formats
    localparam logic [FMT_W-1:0] FMT_FLOAT32   = 3'd0;
    localparam logic [FMT_W-1:0] FMT_INT16     = 3'd1;
    localparam logic [FMT_W-1:0] FMT_INT24     = 3'd2;
    localparam logic [FMT_W-1:0] FMT_INT24_IN32 = 3'd3;
    localparam logic [FMT_W-1:0] FMT_INT32     = 3'd4;

    localparam logic [FMT_W-1:0]   FMT_RESET   = FMT_INT16;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd2;

    localparam logic [30:0]       SAT_Q23 = 31'h4000_0000;
    localparam logic [MONO_W-1:0] ONE_Q23 = 25'h080_0000;

    typedef struct packed {
        logic [31:0] sample_word;
        logic        silent;
        logic        end_of_packet;
    } in_req_t;

    typedef struct packed {
        logic signed [MONO_W-1:0] mono_sample;
        logic                     packet_end;
    } out_req_t;

endpackage

// ===== rtl/pmd_front.sv =====
// Front end: config registers, sample decode and per-frame channel accumulation.
module pmd_front #(
    parameter int MAX_CHANNELS = pmd_pkg::MAX_CHANNELS_DEF,
    localparam int SUM_W = 33 + $clog2(MAX_CHANNELS),
    localparam int CNT_W = $clog2(MAX_CHANNELS + 1)
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    input  logic [pmd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pmd_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  pmd_pkg::in_req_t                 in_data,
    output logic                             push,
    output logic signed [SUM_W-1:0]          push_sum,
    output logic [CNT_W-1:0]                 push_count,
    output logic                             push_eop,
    input  logic                             full
);
    import pmd_pkg::*;

    logic [FMT_W-1:0]          fmt_reg;
    logic [COUNT_W-1:0]        count_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic [CNT_W-1:0]          pos_reg;
    logic                      eop_reg;

    logic [CNT_W-1:0]          cnt_eff;
    logic [CNT_W:0]            pos_inc;
    logic                      last;
    logic                      supported;
    logic                      accept;
    logic                      cfg_hit;
    logic signed [31:0]        sample_val;
    logic signed [SUM_W-1:0]   sum_add;

    function automatic logic signed [31:0] decode_float(input logic [31:0] w);
        logic [7:0]  expo;
        logic [23:0] mant;
        logic [30:0] mag;
        logic [30:0] wide;
        logic [7:0]  rsh;
        expo = w[30:23];
        mant = {1'b1, w[22:0]};
        wide = {7'd0, mant};
        rsh  = 8'd127 - expo;
        if (expo == 8'hFF) begin
            mag = (w[22:0] != 23'd0) ? 31'd0 : SAT_Q23;
        end
        else if (expo == 8'd0) begin
            mag = 31'd0;
        end
        else if (expo >= 8'd134) begin
            mag = SAT_Q23;
        end
        else if (expo >= 8'd127) begin
            mag = wide << (expo - 8'd127);
        end
        else if (rsh >= 8'd24) begin
            mag = 31'd0;
        end
        else begin
            mag = wide >> rsh;
        end
        if (mag > SAT_Q23) begin
            mag = SAT_Q23;
        end
        return w[31] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

    always_comb
    begin
        if (count_reg == '0) begin
            cnt_eff = CNT_W'(1);
        end
        else if (int'(count_reg) > MAX_CHANNELS) begin
            cnt_eff = CNT_W'(MAX_CHANNELS);
        end
        else begin
            cnt_eff = CNT_W'(count_reg);
        end
    end

    always_comb
    begin
        unique case (fmt_reg)
            FMT_FLOAT32: sample_val = decode_float(in_data.sample_word);
            FMT_INT16:   sample_val = {{8{in_data.sample_word[15]}},
                                       in_data.sample_word[15:0], 8'd0};
            FMT_INT24:   sample_val = {{8{in_data.sample_word[23]}},
                                       in_data.sample_word[23:0]};
            default:     sample_val = {{8{in_data.sample_word[31]}},
                                       in_data.sample_word[31:8]};
        endcase
    end

    assign pos_inc   = {1'b0, pos_reg} + (CNT_W + 1)'(1);
    assign last      = pos_inc >= {1'b0, cnt_eff};
    assign supported = fmt_reg <= FMT_INT32;
    assign in_stall  = supported & last & full;
    assign accept    = in_valid & ~in_stall;
    assign cfg_hit   = cfg_valid & ((cfg_index == REG_FORMAT) | (cfg_index == REG_COUNT));

    assign sum_add = in_data.silent ? sum_reg
                                    : sum_reg + SUM_W'(sample_val);

    assign push       = accept & supported & last;
    assign push_sum   = sum_add;
    assign push_count = cnt_eff;
    assign push_eop   = eop_reg | in_data.end_of_packet;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            fmt_reg   <= FMT_RESET;
            count_reg <= COUNT_RESET;
            sum_reg   <= '0;
            pos_reg   <= '0;
            eop_reg   <= 1'b0;
        end
        else if (cfg_hit) begin
            // any register write drops the partial frame
            if (cfg_index == REG_FORMAT) begin
                fmt_reg <= cfg_data[FMT_W-1:0];
            end
            else begin
                count_reg <= cfg_data[COUNT_W-1:0];
            end
            sum_reg <= '0;
            pos_reg <= '0;
            eop_reg <= 1'b0;
        end
        else if (accept && supported) begin
            if (last) begin
                sum_reg <= '0;
                pos_reg <= '0;
                eop_reg <= 1'b0;
            end
            else begin
                sum_reg <= sum_add;
                pos_reg <= pos_inc[CNT_W-1:0];
                eop_reg <= push_eop;
            end
        end
    end

endmodule

// ===== rtl/pmd_fifo.sv =====
// Two-entry queue carrying finished frame sums from the front end to the divider.
module pmd_fifo #(
    parameter int W = 40
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] pop_data,
    output logic         not_empty
);
    import pmd_pkg::*;

    logic [W-1:0] mem_reg [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   count_reg;
    logic         do_push;
    logic         do_pop;

    assign full      = count_reg == 2'd2;
    assign not_empty = count_reg != 2'd0;
    assign pop_data  = mem_reg[rd_ptr_reg];
    assign do_push   = push & ~full;
    assign do_pop    = pop & not_empty;

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else begin
            if (do_push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ===== rtl/pmd_back.sv =====
// Back end: bit-serial sum/count divide, clamp to Q1.23 and output register.
module pmd_back #(
    parameter int MAX_CHANNELS = pmd_pkg::MAX_CHANNELS_DEF,
    localparam int SUM_W = 33 + $clog2(MAX_CHANNELS),
    localparam int CNT_W = $clog2(MAX_CHANNELS + 1)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    frame_valid,
    output logic                    pop,
    input  logic signed [SUM_W-1:0] frame_sum,
    input  logic [CNT_W-1:0]        frame_count,
    input  logic                    frame_eop,
    output logic                    out_valid,
    input  logic                    out_stall,
    output pmd_pkg::out_req_t       out_data
);
    import pmd_pkg::*;

    localparam int IT_W = $clog2(SUM_W);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [SUM_W-1:0]  quo_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  div_reg;
    logic              neg_reg;
    logic              eop_reg;
    logic [IT_W-1:0]   iter_reg;
    logic              out_valid_reg;
    out_req_t          out_data_reg;

    logic [CNT_W:0]    shifted;
    logic [CNT_W:0]    diff;
    logic              ge;
    logic [MONO_W-1:0] mag;
    logic              can_load;

    assign shifted = {rem_reg, quo_reg[SUM_W-1]};
    assign diff    = shifted - {1'b0, div_reg};
    assign ge      = shifted >= {1'b0, div_reg};

    // quotient magnitude clamped to 1.0
    assign mag = (quo_reg > SUM_W'(ONE_Q23)) ? ONE_Q23 : quo_reg[MONO_W-1:0];

    assign can_load  = ~out_valid_reg | ~out_stall;
    assign pop       = (state_reg == ST_IDLE) & frame_valid;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (frame_valid) state_next = ST_DIV;
            ST_DIV:  if (iter_reg == '0) state_next = ST_DONE;
            ST_DONE: if (can_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                quo_reg <= frame_sum[SUM_W-1] ? SUM_W'(-frame_sum) : SUM_W'(frame_sum);
                neg_reg <= frame_sum[SUM_W-1];
                div_reg <= frame_count;
                eop_reg <= frame_eop;
                rem_reg <= '0;
            end
            ST_DIV:
            begin
                quo_reg <= {quo_reg[SUM_W-2:0], ge};
                rem_reg <= ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
            end
            default:
            begin
                quo_reg <= quo_reg;
            end
        endcase
        if (state_reg == ST_DONE && can_load) begin
            out_data_reg.mono_sample <= neg_reg ? -$signed(mag) : $signed(mag);
            out_data_reg.packet_end  <= eop_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE) begin
                iter_reg <= IT_W'(SUM_W - 1);
            end
            else if (state_reg == ST_DIV) begin
                iter_reg <= iter_reg - IT_W'(1);
            end
            if (state_reg == ST_DONE && can_load) begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/pcm_multichannel_to_mono_downmix_top.sv =====
// Top level of the multichannel PCM to mono downmix block.
// Input channel: one interleaved channel sample per request (in_valid/in_stall),
// a 32-bit little-endian container plus silent and end-of-packet marks.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 sample format,
// index 1 channel count; a write drops any partially collected frame.
// Output channel (out_valid/out_stall): one Q1.23 mono request per frame.
// The front end takes one sample per cycle while not stalled and
// accumulates the frame sum. A finished frame goes through a two-entry
// queue to a bit-serial divider that retires one quotient bit per cycle
// over the full sum width (36 bits at 8 channels); a frame passes the back
// end as a load step, one divide step per quotient bit and an output step,
// and the back end takes the next frame only once the current one is out.
// Samples go in at one per cycle until two frames wait in the queue.
// The front end stalls only on a frame's last sample when the queue is full.
// A stalled output holds; the divider may finish the next frame meanwhile.
// Reset sets format int16, two channels, and an empty frame and queue.
// Unsupported formats accept samples and drop them.
module pcm_multichannel_to_mono_downmix_top #(
    parameter int MAX_CHANNELS = pmd_pkg::MAX_CHANNELS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pmd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pmd_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  pmd_pkg::in_req_t               in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output pmd_pkg::out_req_t              out_data
);
    import pmd_pkg::*;

    localparam int SUM_W = 33 + $clog2(MAX_CHANNELS);
    localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
    localparam int Q_W   = SUM_W + CNT_W + 1;

    logic                    push;
    logic signed [SUM_W-1:0] push_sum;
    logic [CNT_W-1:0]        push_count;
    logic                    push_eop;
    logic                    full;
    logic                    pop;
    logic [Q_W-1:0]          pop_data;
    logic                    not_empty;

    assign cfg_ready = 1'b1;

    pmd_front #(
        .MAX_CHANNELS(MAX_CHANNELS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .push       (push),
        .push_sum   (push_sum),
        .push_count (push_count),
        .push_eop   (push_eop),
        .full       (full)
    );

    pmd_fifo #(
        .W(Q_W)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_sum, push_count, push_eop}),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .not_empty (not_empty)
    );

    pmd_back #(
        .MAX_CHANNELS(MAX_CHANNELS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (not_empty),
        .pop         (pop),
        .frame_sum   ($signed(pop_data[Q_W-1 -: SUM_W])),
        .frame_count (pop_data[CNT_W:1]),
        .frame_eop   (pop_data[0]),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data)
    );

endmodule
